FILE: sv/vwtl_pkg.sv
// ----------------------------------------------------------------------------
// vwtl_pkg
// Shared types, widths and tables of the video wall tile placer.
// ----------------------------------------------------------------------------
package vwtl_pkg;

  localparam int unsigned DimW      = 13;
  localparam int unsigned PosW      = 12;
  localparam int unsigned CntW      = 7;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned ProdW     = 2 * DimW;
  localparam int unsigned DvdW      = ProdW + 1;
  localparam int unsigned DvsW      = DimW + 1;
  localparam int unsigned DivCntW   = $clog2(DvdW);
  localparam int unsigned SqrtW     = 4;
  localparam int unsigned SideW     = 5;
  localparam int unsigned GProdW    = 10;

  localparam int unsigned DefMaxCells     = 64;
  localparam int unsigned DefMaxDisplayDim = 4096;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_DISPLAY_WIDTH  = 3'd0,
    REG_DISPLAY_HEIGHT = 3'd1,
    REG_LAYOUT_MODE    = 3'd2,
    REG_CELL_COUNT     = 3'd3,
    REG_CUSTOM_ROWS    = 3'd4,
    REG_CUSTOM_COLS    = 3'd5
  } reg_idx_e;

  localparam logic [DimW-1:0] RstDisplayWidth  = 13'd1920;
  localparam logic [DimW-1:0] RstDisplayHeight = 13'd1080;

  typedef struct packed {
    logic [DimW-1:0] display_width;
    logic [DimW-1:0] display_height;
    logic            layout_mode;
    logic [CntW-1:0] cell_count;
    logic [CntW-1:0] user_rows;
    logic [CntW-1:0] user_cols;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic [CntW-1:0] rows;
    logic [CntW-1:0] cols;
  } grid_t;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] quotient;
    logic [DvsW-1:0] remainder;
  } div_rsp_t;

  typedef logic [SqrtW-1:0] sqrt_lut_t [2**CntW];

  function automatic sqrt_lut_t sqrt_lut_f();
    sqrt_lut_t lut;
    int unsigned s;
    for (int unsigned n = 0; n < 2**CntW; n++) begin
      s = 0;
      while ((s + 1) * (s + 1) <= n) s++;
      lut[n] = SqrtW'(s);
    end
    return lut;
  endfunction

  localparam sqrt_lut_t SqrtLut = sqrt_lut_f();

endpackage

FILE: sv/vwtl_if.sv
// ----------------------------------------------------------------------------
// vwtl interfaces
// Request, result and configuration channels of the tile placer.
// ----------------------------------------------------------------------------
interface vwtl_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  cell_index;
  logic [12:0] source_width;
  logic [12:0] source_height;
  modport source (output valid, cell_index, source_width, source_height, input ready);
  modport sink   (input valid, cell_index, source_width, source_height, output ready);
endinterface

interface vwtl_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [11:0] tile_x;
  logic [11:0] tile_y;
  logic [12:0] tile_width;
  logic [12:0] tile_height;
  logic [12:0] dest_x;
  logic [12:0] dest_y;
  logic [12:0] dest_width;
  logic [12:0] dest_height;
  modport source (output valid, status, tile_x, tile_y, tile_width, tile_height,
                  dest_x, dest_y, dest_width, dest_height, input ready);
  modport sink   (input valid, status, tile_x, tile_y, tile_width, tile_height,
                  dest_x, dest_y, dest_width, dest_height, output ready);
endinterface

interface vwtl_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/vwtl_div.sv
// ----------------------------------------------------------------------------
// vwtl_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vwtl_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vwtl_pkg::div_req_t req_i,
  output vwtl_pkg::div_rsp_t rsp_o
);
  import vwtl_pkg::*;

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DvdW-1:0]    quo_q;
  logic [DvsW-1:0]    rem_q, dvs_q;
  logic [DvsW:0]      rem_sh;
  logic               ge;
  logic [DvsW-1:0]    rem_d;

  always_comb begin
    rem_sh = {rem_q, quo_q[DvdW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? DvsW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DvsW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DvdW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DvdW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

FILE: sv/vwtl_grid.sv
// ----------------------------------------------------------------------------
// vwtl_grid
// Picks the grid from the registers: near-square search or custom size.
// ----------------------------------------------------------------------------
module vwtl_grid #(
  parameter int unsigned MAX_CELLS       = vwtl_pkg::DefMaxCells,
  parameter int unsigned MAX_DISPLAY_DIM = vwtl_pkg::DefMaxDisplayDim
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vwtl_pkg::cfg_t  cfg_i,
  input  logic            written_i,
  output vwtl_pkg::grid_t grid_o
);
  import vwtl_pkg::*;

  grid_t             grid_d, grid_q;
  logic [GProdW-1:0] n, best_e, lo, cm1, csq, cp1, e;
  logic [SideW-1:0]  s, c, r;
  logic [CntW-1:0]   br, bc;
  logic              base_ok, cand, wide;
  logic [2*CntW-1:0] cust_prod;

  always_comb begin
    n       = GProdW'(cfg_i.cell_count);
    base_ok = written_i && (n != '0) && (n <= GProdW'(MAX_CELLS))
              && (cfg_i.display_width != '0) && (cfg_i.display_height != '0)
              && ({19'd0, cfg_i.display_width} <= MAX_DISPLAY_DIM)
              && ({19'd0, cfg_i.display_height} <= MAX_DISPLAY_DIM);
    wide    = cfg_i.display_width >= cfg_i.display_height;
    s       = SideW'(SqrtLut[cfg_i.cell_count]);
    best_e  = n;
    br      = '0;
    bc      = '0;
    lo = '0; cm1 = '0; csq = '0; cp1 = '0; e = '0; c = '0; r = '0; cand = 1'b0;
    // three candidate column counts, ties to the later one
    for (int k = 0; k < 3; k++) begin
      c    = s + SideW'(k);
      lo   = (c >= SideW'(2)) ? GProdW'(c * (c - SideW'(2))) : '0;
      cm1  = (c >= SideW'(1)) ? GProdW'(c * (c - SideW'(1))) : '0;
      csq  = GProdW'(c * c);
      cp1  = GProdW'(c * (c + SideW'(1)));
      cand = 1'b1;
      if (c >= SideW'(2) && n > lo && n <= cm1) begin
        r = c - SideW'(1); e = cm1 - n;
      end else if (n > cm1 && n <= csq) begin
        r = c;             e = csq - n;
      end else if (n > csq && n <= cp1) begin
        r = c + SideW'(1); e = cp1 - n;
      end else begin
        r = '0; e = '0; cand = 1'b0;
      end
      if (cand && e <= best_e) begin
        best_e = e;
        br     = wide ? CntW'(r) : CntW'(c);
        bc     = wide ? CntW'(c) : CntW'(r);
      end
    end
    cust_prod = cfg_i.user_rows * cfg_i.user_cols;
    grid_d    = '0;
    if (base_ok) begin
      if (!cfg_i.layout_mode) begin
        if (br != '0 && bc != '0) begin
          grid_d.valid = 1'b1;
          grid_d.rows  = br;
          grid_d.cols  = bc;
        end
      end else if (cfg_i.user_rows != '0 && cfg_i.user_cols != '0
                   && cust_prod >= {7'd0, cfg_i.cell_count}) begin
        grid_d.valid = 1'b1;
        grid_d.rows  = cfg_i.user_rows;
        grid_d.cols  = cfg_i.user_cols;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) grid_q <= '0;
    else         grid_q <= grid_d;
  end

  assign grid_o = grid_q;

endmodule

FILE: sv/video_wall_tile_layout.sv
// ----------------------------------------------------------------------------
// video_wall_tile_layout
// Places source frames into the cells of a video wall grid with letterbox fit.
// ----------------------------------------------------------------------------
// One request at a time. A rejected request goes to the done state and then to
// the output register; the next request is taken once the block is idle again.
// A placed request runs three divisions (cell index, width, height by the grid)
// on the shared divider, one after another, before its result is registered.
// The first placed request after reset or a register write adds two more
// divisions for the letterbox fit. A stalled result holds the block in its done
// state. The grid is recomputed in the cycle after each register write, during
// which no request is taken. The result waits in an output register.
module video_wall_tile_layout #(
  parameter int unsigned MAX_CELLS       = vwtl_pkg::DefMaxCells,
  parameter int unsigned MAX_DISPLAY_DIM = vwtl_pkg::DefMaxDisplayDim
) (
  input  logic clk_i,
  input  logic rst_ni,
  vwtl_cfg_if.sink   cfg_i,
  vwtl_in_if.sink    in_i,
  vwtl_out_if.source out_o
);
  import vwtl_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_DIV_IDX  = 12'b0000_0000_0010,
    ST_DIV_W    = 12'b0000_0000_0100,
    ST_DIV_H    = 12'b0000_0000_1000,
    ST_GEOM_X   = 12'b0000_0001_0000,
    ST_GEOM_Y   = 12'b0000_0010_0000,
    ST_PROD_A   = 12'b0000_0100_0000,
    ST_PROD_B   = 12'b0000_1000_0000,
    ST_FIT_GO   = 12'b0001_0000_0000,
    ST_FIT_SIZE = 12'b0010_0000_0000,
    ST_FIT_OFS  = 12'b0100_0000_0000,
    ST_DONE     = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  cfg_t   cfg_q;
  grid_t  grid;
  logic   written_q, pend_q, fit_latched_q;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [DimW-1:0]  sw_q, sh_q, cw_q, ch_q, x_q, y_q, w_q, h_q;
  logic [CntW-1:0]  row_q, col_q, wr_q, hr_q;
  logic [ProdW-1:0] pa_q, pb_q;
  logic             reject_q, use_w_q;
  logic [DimW-1:0]  fit_w_q, fit_h_q;
  logic [PosW-1:0]  fit_ox_q, fit_oy_q;
  logic             out_vld_q;

  logic             cfg_fire, cfg_hit, in_fire, out_free;
  logic [DimW-1:0]  sw_in, sh_in;
  logic [2*DimW+CntW-1:0] lin;
  logic [DimW-1:0]  pos_d, size_d;

  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign cfg_hit  = cfg_fire && (cfg_i.index <= REG_CUSTOM_COLS);
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE) && !pend_q;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;
  assign sw_in    = (in_i.source_width  == '0) ? DimW'(1) : in_i.source_width;
  assign sh_in    = (in_i.source_height == '0) ? DimW'(1) : in_i.source_height;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.display_width  <= RstDisplayWidth;
      cfg_q.display_height <= RstDisplayHeight;
      cfg_q.layout_mode    <= 1'b0;
      cfg_q.cell_count     <= CntW'(1);
      cfg_q.user_rows      <= CntW'(1);
      cfg_q.user_cols      <= CntW'(1);
      written_q            <= 1'b0;
      pend_q               <= 1'b0;
    end else begin
      pend_q <= cfg_hit;
      if (cfg_hit) written_q <= 1'b1;
      if (cfg_fire) begin
        case (reg_idx_e'(cfg_i.index))
          REG_DISPLAY_WIDTH:  cfg_q.display_width  <= cfg_i.data;
          REG_DISPLAY_HEIGHT: cfg_q.display_height <= cfg_i.data;
          REG_LAYOUT_MODE:    cfg_q.layout_mode    <= cfg_i.data[0];
          REG_CELL_COUNT:     cfg_q.cell_count     <= cfg_i.data[CntW-1:0];
          REG_CUSTOM_ROWS:    cfg_q.user_rows      <= cfg_i.data[CntW-1:0];
          REG_CUSTOM_COLS:    cfg_q.user_cols      <= cfg_i.data[CntW-1:0];
          default: ;
        endcase
      end
    end
  end

  vwtl_grid #(
    .MAX_CELLS      (MAX_CELLS),
    .MAX_DISPLAY_DIM(MAX_DISPLAY_DIM)
  ) u_grid (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .written_i(written_q),
    .grid_o   (grid)
  );

  vwtl_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // sequencer and divider operand selection
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = DvsW'(1);
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!grid.valid || {1'b0, in_i.cell_index} >= cfg_q.cell_count) begin
            state_d = ST_DONE;
          end else begin
            state_d          = ST_DIV_IDX;
            div_req.start    = 1'b1;
            div_req.dividend = DvdW'(in_i.cell_index);
            div_req.divisor  = DvsW'(grid.cols);
          end
        end
      end
      ST_DIV_IDX: begin
        if (div_rsp.done) begin
          state_d          = ST_DIV_W;
          div_req.start    = 1'b1;
          div_req.dividend = DvdW'(cfg_q.display_width);
          div_req.divisor  = DvsW'(grid.cols);
        end
      end
      ST_DIV_W: begin
        if (div_rsp.done) begin
          state_d          = ST_DIV_H;
          div_req.start    = 1'b1;
          div_req.dividend = DvdW'(cfg_q.display_height);
          div_req.divisor  = DvsW'(grid.rows);
        end
      end
      ST_DIV_H:  if (div_rsp.done) state_d = ST_GEOM_X;
      ST_GEOM_X: state_d = ST_GEOM_Y;
      ST_GEOM_Y: state_d = fit_latched_q ? ST_DONE : ST_PROD_A;
      ST_PROD_A: state_d = ST_PROD_B;
      ST_PROD_B: state_d = ST_FIT_GO;
      ST_FIT_GO: begin
        state_d       = ST_FIT_SIZE;
        div_req.start = 1'b1;
        if (pa_q <= pb_q) begin
          div_req.dividend = DvdW'(pa_q);
          div_req.divisor  = DvsW'(sw_q);
        end else begin
          div_req.dividend = DvdW'(pb_q);
          div_req.divisor  = DvsW'(sh_q);
        end
      end
      ST_FIT_SIZE: begin
        if (div_rsp.done) begin
          state_d       = ST_FIT_OFS;
          div_req.start = 1'b1;
          if (use_w_q) begin
            div_req.dividend = DvdW'(pb_q - pa_q);
            div_req.divisor  = {sw_q, 1'b0};
          end else begin
            div_req.dividend = DvdW'(pa_q - pb_q);
            div_req.divisor  = {sh_q, 1'b0};
          end
        end
      end
      ST_FIT_OFS: if (div_rsp.done) state_d = ST_DONE;
      ST_DONE:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // position along one axis: index * base + min(index, remainder)
  always_comb begin
    if (state_q == ST_GEOM_X) begin
      lin    = (2*DimW+CntW)'(col_q * cw_q);
      pos_d  = DimW'(lin + ((col_q < wr_q) ? (2*DimW+CntW)'(col_q) : (2*DimW+CntW)'(wr_q)));
      size_d = cw_q + ((col_q < wr_q) ? DimW'(1) : DimW'(0));
    end else begin
      lin    = (2*DimW+CntW)'(row_q * ch_q);
      pos_d  = DimW'(lin + ((row_q < hr_q) ? (2*DimW+CntW)'(row_q) : (2*DimW+CntW)'(hr_q)));
      size_d = ch_q + ((row_q < hr_q) ? DimW'(1) : DimW'(0));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      fit_latched_q <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_hit) fit_latched_q <= 1'b0;
      else if (state_q == ST_FIT_OFS && div_rsp.done) fit_latched_q <= 1'b1;
      if (state_q == ST_DONE && out_free) out_vld_q <= 1'b1;
      else if (out_o.ready)               out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        sw_q     <= sw_in;
        sh_q     <= sh_in;
        reject_q <= !grid.valid || {1'b0, in_i.cell_index} >= cfg_q.cell_count;
      end
      ST_DIV_IDX: begin
        row_q <= div_rsp.quotient[CntW-1:0];
        col_q <= div_rsp.remainder[CntW-1:0];
      end
      ST_DIV_W: begin
        cw_q <= div_rsp.quotient[DimW-1:0];
        wr_q <= div_rsp.remainder[CntW-1:0];
      end
      ST_DIV_H: begin
        ch_q <= div_rsp.quotient[DimW-1:0];
        hr_q <= div_rsp.remainder[CntW-1:0];
      end
      ST_GEOM_X: begin
        x_q <= pos_d;
        w_q <= size_d;
      end
      ST_GEOM_Y: begin
        y_q <= pos_d;
        h_q <= size_d;
      end
      ST_PROD_A: pa_q <= w_q * sh_q;
      ST_PROD_B: pb_q <= h_q * sw_q;
      ST_FIT_GO: use_w_q <= pa_q <= pb_q;
      ST_FIT_SIZE: begin
        if (use_w_q) begin
          fit_w_q <= w_q;
          fit_h_q <= div_rsp.quotient[DimW-1:0];
        end else begin
          fit_w_q <= div_rsp.quotient[DimW-1:0];
          fit_h_q <= h_q;
        end
      end
      ST_FIT_OFS: begin
        fit_ox_q <= use_w_q ? '0 : div_rsp.quotient[PosW-1:0];
        fit_oy_q <= use_w_q ? div_rsp.quotient[PosW-1:0] : '0;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_o.status <= reject_q;
      if (reject_q) begin
        out_o.tile_x      <= '0;
        out_o.tile_y      <= '0;
        out_o.tile_width  <= '0;
        out_o.tile_height <= '0;
        out_o.dest_x      <= '0;
        out_o.dest_y      <= '0;
        out_o.dest_width  <= '0;
        out_o.dest_height <= '0;
      end else begin
        out_o.tile_x      <= x_q[PosW-1:0];
        out_o.tile_y      <= y_q[PosW-1:0];
        out_o.tile_width  <= w_q;
        out_o.tile_height <= h_q;
        out_o.dest_x      <= x_q + DimW'(fit_ox_q);
        out_o.dest_y      <= y_q + DimW'(fit_oy_q);
        out_o.dest_width  <= fit_w_q;
        out_o.dest_height <= fit_h_q;
      end
    end
  end

  assign out_o.valid = out_vld_q;

endmodule

FILE: sv/vwtl_chk.sv
// ----------------------------------------------------------------------------
// vwtl_chk
// Port-level checks of the tile placer, bound to the top level.
// ----------------------------------------------------------------------------
module vwtl_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        cfg_valid_i,
  input logic        cfg_ready_i,
  input logic [2:0]  cfg_index_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_status_i,
  input logic [11:0] out_tile_x_i,
  input logic [12:0] out_tile_width_i,
  input logic [12:0] out_dest_x_i,
  input logic [12:0] out_dest_width_i
);
  import vwtl_pkg::*;

  // a result waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // one item in flight at a time
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

  // grid is recomputed after a register write
  a_cfg_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_i && cfg_index_i <= REG_CUSTOM_COLS |=> !in_ready_i)
    else $error("request taken during relayout");

  // rejected items carry no geometry
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i |-> out_tile_width_i == '0 && out_dest_width_i == '0)
    else $error("rejected item with geometry");

  // letterbox offset never moves left of the cell
  a_dest_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_status_i |-> out_dest_x_i >= {1'b0, out_tile_x_i})
    else $error("destination left of cell");

endmodule

bind video_wall_tile_layout vwtl_chk u_vwtl_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .cfg_valid_i     (cfg_i.valid),
  .cfg_ready_i     (cfg_i.ready),
  .cfg_index_i     (cfg_i.index),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_status_i    (out_o.status),
  .out_tile_x_i    (out_o.tile_x),
  .out_tile_width_i(out_o.tile_width),
  .out_dest_x_i    (out_o.dest_x),
  .out_dest_width_i(out_o.dest_width)
);
